// ----- rtl/hsc_pkg.sv -----
// Package: payload types, divider lane types and constants for the color converter.
package hsc_pkg;

   localparam int RemW     = 18;   // dividend / remainder width
   localparam int DenW     = 10;   // doubled divisor width
   localparam int QuoW     = 9;    // quotient bits, one per cell
   localparam int NumLanes = 7;

   // lane codes, one division per output field
   localparam int LaneHue  = 0;
   localparam int LaneSat  = 1;
   localparam int LaneLig  = 2;
   localparam int LaneCyan = 3;
   localparam int LaneMag  = 4;
   localparam int LaneYel  = 5;
   localparam int LaneKey  = 6;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } req_type;

   typedef struct packed {
      logic [8:0] hue;
      logic [6:0] saturation;
      logic [6:0] lightness;
      logic [6:0] cyan;
      logic [6:0] magenta;
      logic [6:0] yellow_part;
      logic [6:0] key_black;
   } rsp_type;

   typedef struct packed {
      logic [RemW-1:0] rem;
      logic [DenW-1:0] den;
      logic [QuoW-1:0] quo;
   } lane_type;

   typedef lane_type [NumLanes-1:0] stage_type;

endpackage

// ----- rtl/rgb_to_hsl_cmyk_converter.sv -----
// Top level: RGB pixel to HSL and CMYK, front cell plus a row of divider cells.
//
// Input: drive req_data with start high; a beat is taken at each edge where
// start is high and busy is low. busy is always low, so a pixel may enter
// every cycle.
// Output: rsp_valid marks one cycle in which rsp_data holds the result beat;
// the receiver must take it then, it cannot stall the block.
// Pipeline: the front cell registers the accepted pixel, then nine divider
// cells follow, one quotient bit each; rsp_valid rises as the last cell
// registers the result. Throughput: one pixel per cycle,
// set by the fully pipelined row of divider cells.
// Results leave in the order pixels came in.
// Reset (synchronous, active high) clears all valid flags; pixels in flight
// are dropped and no result beat follows until new pixels enter.
module rgb_to_hsl_cmyk_converter (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  hsc_pkg::req_type req_data,
   output logic             rsp_valid,
   output hsc_pkg::rsp_type rsp_data
);
   import hsc_pkg::*;

   logic      valid [QuoW+1];
   stage_type stage [QuoW+1];

   assign busy = 1'b0;

   hsc_prep u_prep (
      .clock, .reset,
      .valid_i (start & ~busy),
      .pix_i   (req_data),
      .valid_o (valid[0]),
      .stage_o (stage[0])
   );

   // one cell per quotient bit, most significant first
   for (genvar k = 0; k < QuoW; k++) begin : g_cell
      hsc_div_cell #(.Shift(QuoW - 1 - k)) u_cell (
         .clock, .reset,
         .valid_i (valid[k]),
         .stage_i (stage[k]),
         .valid_o (valid[k+1]),
         .stage_o (stage[k+1])
      );
   end

   assign rsp_valid            = valid[QuoW];
   assign rsp_data.hue         = stage[QuoW][LaneHue].quo;
   assign rsp_data.saturation  = stage[QuoW][LaneSat].quo[6:0];
   assign rsp_data.lightness   = stage[QuoW][LaneLig].quo[6:0];
   assign rsp_data.cyan        = stage[QuoW][LaneCyan].quo[6:0];
   assign rsp_data.magenta     = stage[QuoW][LaneMag].quo[6:0];
   assign rsp_data.yellow_part = stage[QuoW][LaneYel].quo[6:0];
   assign rsp_data.key_black   = stage[QuoW][LaneKey].quo[6:0];
endmodule

// ----- rtl/hsc_prep.sv -----
// Front cell: max/min, and the rounded dividend and divisor for each lane.
module hsc_prep (
   input  logic              clock,
   input  logic              reset,
   input  logic              valid_i,
   input  hsc_pkg::req_type  pix_i,
   output logic              valid_o,
   output hsc_pkg::stage_type stage_o
);
   import hsc_pkg::*;

   logic [7:0]  r, g, b, mx, mn, d;
   logic [8:0]  sum, sat_den;
   logic [18:0] hue_num;
   logic [16:0] sat_num, cmy_num [3];
   logic [7:0]  comp [3];
   stage_type   stage_in, stage_ff;
   logic        valid_ff;

   // build one lane: dividend 2*num+den, divisor 2*den
   function automatic lane_type mk(input logic [18:0] num, input logic [8:0] den);
      lane_type l;
      l.rem = RemW'({num, 1'b0} + 20'(den));
      l.den = {den, 1'b0};
      l.quo = '0;
      return l;
   endfunction

   always_comb begin
      r = pix_i.red; g = pix_i.green; b = pix_i.blue;
      mx = r; mn = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      d   = mx - mn;
      sum = 9'(mx) + 9'(mn);
      sat_den = (sum > 9'd255) ? 9'd510 - sum : sum;
      sat_num = 17'(d) * 17'd100;
      // sector numerator, red then green then blue on ties
      if (mx == r) begin
         if (g < b) hue_num = 19'd360 * 19'(d) - 19'd60 * 19'(b - g);
         else       hue_num = 19'd60 * 19'(g - b);
      end else if (mx == g) begin
         hue_num = 19'd120 * 19'(d) + 19'd60 * 19'(b) - 19'd60 * 19'(r);
      end else begin
         hue_num = 19'd240 * 19'(d) + 19'd60 * 19'(r) - 19'd60 * 19'(g);
      end
      comp[0] = r; comp[1] = g; comp[2] = b;
      for (int i = 0; i < 3; i++) cmy_num[i] = 17'(mx - comp[i]) * 17'd100;

      // grey pixel: hue and saturation forced to zero
      if (d == 8'd0) begin
         stage_in[LaneHue] = mk('0, 9'd1);
         stage_in[LaneSat] = mk('0, 9'd1);
      end else begin
         stage_in[LaneHue] = mk(hue_num, 9'(d));
         stage_in[LaneSat] = mk(19'(sat_num), sat_den);
      end
      stage_in[LaneLig] = mk(19'd100 * 19'(sum), 9'd510);
      stage_in[LaneKey] = mk(19'd100 * 19'(8'd255 - mx), 9'd255);
      // black pixel: cyan, magenta, yellow zero
      for (int i = 0; i < 3; i++) begin
         if (mx == 8'd0) stage_in[LaneCyan + i] = mk('0, 9'd1);
         else            stage_in[LaneCyan + i] = mk(19'(cmy_num[i]), 9'(mx));
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_i;
   end

   assign valid_o = valid_ff;
   assign stage_o = stage_ff;
endmodule

// ----- rtl/hsc_div_cell.sv -----
// Divider cell: one restoring quotient bit for every lane.
module hsc_div_cell #(
   parameter int Shift = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               valid_i,
   input  hsc_pkg::stage_type stage_i,
   output logic               valid_o,
   output hsc_pkg::stage_type stage_o
);
   import hsc_pkg::*;

   stage_type         stage_in, stage_ff;
   logic              valid_ff;
   logic [RemW:0]     trial [NumLanes];

   // subtract the shifted divisor, keep it if no borrow
   always_comb begin
      for (int i = 0; i < NumLanes; i++) begin
         trial[i] = {1'b0, stage_i[i].rem} - ((RemW+1)'(stage_i[i].den) << Shift);
         stage_in[i].den = stage_i[i].den;
         stage_in[i].quo = {stage_i[i].quo[QuoW-2:0], ~trial[i][RemW]};
         stage_in[i].rem = trial[i][RemW] ? stage_i[i].rem : trial[i][RemW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      stage_ff <= stage_in;
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_i;
   end

   assign valid_o = valid_ff;
   assign stage_o = stage_ff;
endmodule
